### hw/rtl/ped_pkg.sv
`timescale 1ns / 1ps
// Shared types, character constants and helpers for the percent-escape decoder.
package ped_pkg;

	localparam logic [7:0] CHAR_NUL = 8'h00;
	localparam logic [7:0] CHAR_PCT = 8'h25;
	localparam logic [7:0] CHAR_0   = 8'h30;
	localparam logic [7:0] CHAR_9   = 8'h39;
	localparam logic [7:0] CHAR_LA  = 8'h61;
	localparam logic [7:0] CHAR_LF  = 8'h66;
	localparam logic [7:0] CHAR_UA  = 8'h41;
	localparam logic [7:0] CHAR_UF  = 8'h46;
	localparam logic [7:0] HEX_TEN  = 8'd10;

	// Most result items that one input byte can produce.
	localparam int MAX_RESULTS = 3;
	// Entries in the result queue.
	localparam int Q_DEPTH = 4;
	localparam int Q_AW = $clog2(Q_DEPTH);

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_PCT  = 2'd1,
		MODE_HELD = 2'd2
	} mode_t;

	typedef struct packed {
		logic [7:0]  data;
		logic        is_end;
		logic [15:0] count;
	} item_t;

	// Returns {valid, nibble} for one hex digit character of either case.
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [7:0] v;
		begin
			v = 8'd0;
			if (c >= CHAR_0 && c <= CHAR_9) begin
				v = c - CHAR_0;
				hex_decode = {1'b1, v[3:0]};
			end else if (c >= CHAR_LA && c <= CHAR_LF) begin
				v = c - CHAR_LA + HEX_TEN;
				hex_decode = {1'b1, v[3:0]};
			end else if (c >= CHAR_UA && c <= CHAR_UF) begin
				v = c - CHAR_UA + HEX_TEN;
				hex_decode = {1'b1, v[3:0]};
			end else begin
				hex_decode = 5'd0;
			end
		end
	endfunction

endpackage

### hw/rtl/ped_decode.sv
`timescale 1ns / 1ps
// Single-step decode logic: one input byte against the parse state gives up to three items.
module ped_decode #(
	parameter int COUNT_BITS = 16
) (
	input  logic [7:0]            byte_in,
	input  ped_pkg::mode_t        mode_in,
	input  logic [7:0]            held_in,
	input  logic [COUNT_BITS-1:0] count_in,
	input  logic [COUNT_BITS-1:0] limit_in,
	output ped_pkg::mode_t        mode_next,
	output logic [7:0]            held_next,
	output logic [COUNT_BITS-1:0] count_next,
	output logic [1:0]            item_cnt,
	output ped_pkg::item_t        items [ped_pkg::MAX_RESULTS]
);
	import ped_pkg::*;

	localparam int LW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

	logic [4:0]            hex_hi;
	logic [4:0]            hex_lo;
	logic [1:0]            nd;
	logic [7:0]            db [MAX_RESULTS];
	logic                  has_end;
	logic [COUNT_BITS-1:0] cnt;
	logic [1:0]            k;
	logic [LW-1:0]         cnt_ext;
	mode_t                 mode_step;
	logic [7:0]            held_step;

	assign hex_hi = hex_decode(held_in);
	assign hex_lo = hex_decode(byte_in);

	always_comb begin
		nd        = 2'd0;
		has_end   = 1'b0;
		mode_step = mode_in;
		held_step = held_in;
		for (int i = 0; i < MAX_RESULTS; i++) begin
			db[i] = 8'd0;
		end
		case (mode_in)
			MODE_PCT: begin
				if (byte_in == CHAR_NUL) begin
					db[0]   = CHAR_PCT;
					nd      = 2'd1;
					has_end = 1'b1;
				end else begin
					held_step = byte_in;
					mode_step = MODE_HELD;
				end
			end
			MODE_HELD: begin
				if (byte_in == CHAR_NUL) begin
					db[0]   = CHAR_PCT;
					db[1]   = held_in;
					nd      = 2'd2;
					has_end = 1'b1;
				end else if (hex_hi[4] && hex_lo[4]) begin
					db[0]     = {hex_hi[3:0], hex_lo[3:0]};
					nd        = 2'd1;
					mode_step = MODE_IDLE;
				end else if (held_in == CHAR_PCT) begin
					db[0]     = CHAR_PCT;
					nd        = 2'd1;
					held_step = byte_in;
					mode_step = MODE_HELD;
				end else begin
					db[0] = CHAR_PCT;
					db[1] = held_in;
					if (byte_in == CHAR_PCT) begin
						nd        = 2'd2;
						mode_step = MODE_PCT;
					end else begin
						db[2]     = byte_in;
						nd        = 2'd3;
						mode_step = MODE_IDLE;
					end
				end
			end
			default: begin
				if (byte_in == CHAR_NUL) begin
					has_end = 1'b1;
				end else if (byte_in == CHAR_PCT) begin
					mode_step = MODE_PCT;
				end else begin
					db[0]     = byte_in;
					nd        = 2'd1;
					mode_step = MODE_IDLE;
				end
			end
		endcase
	end

	// Bytes past the limit are dropped; the rest are packed in order.
	always_comb begin
		cnt = count_in;
		k   = 2'd0;
		for (int i = 0; i < MAX_RESULTS; i++) begin
			items[i] = '0;
		end
		for (int i = 0; i < MAX_RESULTS; i++) begin
			if (2'(i) < nd && cnt < limit_in) begin
				if (k < 2'(MAX_RESULTS)) begin
					items[k] = '{data: db[i], is_end: 1'b0, count: 16'd0};
				end
				k   = k + 2'd1;
				cnt = cnt + 1'b1;
			end
		end
		cnt_ext = LW'(cnt);
		if (has_end) begin
			if (k < 2'(MAX_RESULTS)) begin
				items[k] = '{data: CHAR_NUL, is_end: 1'b1, count: cnt_ext[15:0]};
			end
			k   = k + 2'd1;
			cnt = '0;
		end
		item_cnt   = k;
		count_next = cnt;
	end

	always_comb begin
		if (has_end) begin
			mode_next = MODE_IDLE;
			held_next = 8'd0;
		end else begin
			mode_next = mode_step;
			held_next = held_step;
		end
	end

endmodule

### hw/rtl/ped_queue.sv
`timescale 1ns / 1ps
// Result queue: takes up to three items per cycle, hands out one item per cycle while the reader takes it.
module ped_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [1:0]     wr_cnt,
	input  ped_pkg::item_t wr_items [ped_pkg::MAX_RESULTS],
	output logic           room,
	output logic           rd_valid,
	output ped_pkg::item_t rd_item,
	input  logic           rd_take
);
	import ped_pkg::*;

	item_t            entries_q [Q_DEPTH];
	logic [Q_AW-1:0]  wr_ptr_q;
	logic [Q_AW-1:0]  rd_ptr_q;
	logic [Q_AW:0]    fill_q;

	assign room     = fill_q <= (Q_AW + 1)'(Q_DEPTH - MAX_RESULTS);
	assign rd_valid = fill_q != '0;
	assign rd_item  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RESULTS; i++) begin
			if (2'(i) < wr_cnt) begin
				entries_q[wr_ptr_q + Q_AW'(i)] <= wr_items[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + Q_AW'(wr_cnt);
			if (rd_take) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			fill_q <= fill_q + (Q_AW + 1)'(wr_cnt) - (Q_AW + 1)'(rd_take);
		end
	end

endmodule

### hw/rtl/percent_escape_decoder_unit.sv
`timescale 1ns / 1ps
// Top level of the percent-escape decoder: input register, decode step and result queue.
//
// The block decodes a percent-escaped string one byte per cycle; a zero byte closes the string
// with an end item that carries the number of decoded bytes kept. A byte is registered on
// acceptance and decoded from that register into up to three result items, which enter a
// four-entry result queue feeding the output port. Input is taken every cycle as long as each
// byte yields at most one result and the output is not stalled. A byte that yields two or three
// results (a failed or cut-off escape) holds up the input until the single output port drains
// the queue; the input stalls while the queue holds more than one item. The user must write
// max_output through the cfg port only while no string is in flight; the block does not enforce it.
module percent_escape_decoder_unit #(
	parameter int COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        is_end,
	output logic [15:0] out_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);
	import ped_pkg::*;

	localparam int LW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

	logic [15:0]           max_output_q;
	logic                  valid_s1;
	logic [7:0]            byte_s1;
	mode_t                 mode_q;
	logic [7:0]            held_q;
	logic [COUNT_BITS-1:0] count_q;

	logic [LW-1:0]         max_ext;
	logic [COUNT_BITS-1:0] limit;
	mode_t                 mode_d;
	logic [7:0]            held_d;
	logic [COUNT_BITS-1:0] count_d;
	logic [1:0]            dec_cnt;
	item_t                 dec_items [MAX_RESULTS];
	logic                  room;
	logic                  fire;
	logic                  in_take;
	item_t                 head;
	logic                  out_take;

	assign cfg_ready = 1'b1;

	// The limit is max_output capped at the largest count the counter can hold.
	assign max_ext = LW'(max_output_q);
	assign limit   = ((max_ext >> COUNT_BITS) == '0) ? max_ext[COUNT_BITS-1:0] : '1;

	assign fire     = valid_s1 && room;
	assign in_stall = valid_s1 && !room;
	assign in_take  = in_valid && !in_stall;
	assign out_take = out_valid && !out_stall;

	ped_decode #(
		.COUNT_BITS(COUNT_BITS)
	) u_decode (
		.byte_in   (byte_s1),
		.mode_in   (mode_q),
		.held_in   (held_q),
		.count_in  (count_q),
		.limit_in  (limit),
		.mode_next (mode_d),
		.held_next (held_d),
		.count_next(count_d),
		.item_cnt  (dec_cnt),
		.items     (dec_items)
	);

	ped_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_cnt  (fire ? dec_cnt : 2'd0),
		.wr_items(dec_items),
		.room    (room),
		.rd_valid(out_valid),
		.rd_item (head),
		.rd_take (out_take)
	);

	assign out_byte  = head.data;
	assign is_end    = head.is_end;
	assign out_count = head.count;

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_output_q <= 16'hFFFF;
			valid_s1     <= 1'b0;
			mode_q       <= MODE_IDLE;
			held_q       <= 8'd0;
			count_q      <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				max_output_q <= cfg_data;
			end
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				mode_q  <= mode_d;
				held_q  <= held_d;
				count_q <= count_d;
			end
		end
	end

endmodule
